// ----- rtl/core/keyframe_interpolation_player_top_assert.svh -----
// Assertion macros for the keyframe interpolation player.
`ifndef KEYFRAME_INTERPOLATION_PLAYER_TOP_ASSERT_SVH
`define KEYFRAME_INTERPOLATION_PLAYER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define KIP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kip assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define KIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kip assertion failed");

`endif

// ----- rtl/core/kip_pkg.sv -----
// Shared types, codes and constants of the keyframe interpolation player.
package kip_pkg;

    localparam int NUM_ANIMS_DEF     = 5;
    localparam int MAX_KEYFRAMES_DEF = 15;
    localparam int NUM_CHANNELS_DEF  = 11;
    localparam logic [11:0] STEPS_RESET = 12'd190;

    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_SAVE   = 3'd1;
    localparam logic [2:0] OP_SELECT = 3'd2;
    localparam logic [2:0] OP_PLAY   = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_STOPPED  = 3'd2;
    localparam logic [2:0] ST_FINISHED = 3'd3;
    localparam logic [2:0] ST_STARTED  = 3'd4;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [3:0]         channel_index;
        logic signed [31:0] channel_value;
        logic [2:0]         anim_index;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               playing;
        logic [3:0]         frame_count;
        logic [3:0]         out_channel;
        logic signed [31:0] out_value;
        logic               last_item;
    } rsp_t;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [32:0] mag;
    } div_req_t;

endpackage

// ----- rtl/core/keyframe_interpolation_player_top.sv -----
// Keyframe interpolation player: set/select/stopped ops go straight to the response; save
// copies the pose into the next keyframe; increments come from a serial divider, and play
// first loads frame 0 into the pose; a plain tick steps every channel, then emits one result per channel.
// One transaction is worked at a time; results drain through a single output register.
// Reset (rst_n, async low) clears pose, increments, counts, play state; steps = 190.
// The keyframe memory has no reset; only written entries are ever used.
module keyframe_interpolation_player_top #(
    parameter int NUM_ANIMS     = kip_pkg::NUM_ANIMS_DEF,
    parameter int MAX_KEYFRAMES = kip_pkg::MAX_KEYFRAMES_DEF,
    parameter int NUM_CHANNELS  = kip_pkg::NUM_CHANNELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  kip_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output kip_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic [11:0]   cfg_wdata
);

    localparam int DEPTH = NUM_ANIMS * MAX_KEYFRAMES * NUM_CHANNELS;
    localparam int KAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AIW   = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
    localparam int CIW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SAVE, S_LOAD_A, S_LOAD_B, S_INC_A, S_INC_B, S_INC_C, S_INC_D,
        S_STEP, S_EMIT
    } state_t;

    state_t             state_reg;
    kip_pkg::cmd_t      cmd_reg;
    logic [CIW-1:0]     c_reg;
    logic signed [31:0] pose_reg [NUM_CHANNELS];
    logic signed [31:0] inc_reg [NUM_CHANNELS];
    logic [3:0]         fcnt_reg [NUM_ANIMS];
    logic [AIW-1:0]     cur_reg;
    logic               play_reg;
    logic [3:0]         seg_reg;
    logic [11:0]        step_reg;
    logic [11:0]        steps_reg;
    logic [2:0]         status_reg;
    logic signed [31:0] cur_val_reg;
    kip_pkg::rsp_t      rsp_reg;
    logic               rsp_valid_reg;

    logic signed [31:0] kf_mem [DEPTH];
    logic signed [31:0] rdata_reg;
    logic [KAW-1:0]     raddr;
    logic [KAW-1:0]     waddr;
    logic               mem_we;
    logic [3:0]         rd_frame;

    logic [3:0]         fcnt_cur;
    logic [11:0]        eff_steps;
    logic [4:0]         seg_inc;
    logic               last_c;
    logic signed [32:0] diff;
    logic signed [32:0] sum;
    logic signed [31:0] sum_sat;
    kip_pkg::div_req_t  div_req;
    logic               div_done;
    logic signed [31:0] div_quot;

    // Decode shared values
    always_comb
    begin
        fcnt_cur  = fcnt_reg[cur_reg];
        eff_steps = (steps_reg == 12'd0) ? 12'd1 : steps_reg;
        seg_inc   = {1'b0, seg_reg} + 5'd1;
        last_c    = int'(c_reg) == NUM_CHANNELS - 1;
        diff      = {rdata_reg[31], rdata_reg} - {cur_val_reg[31], cur_val_reg};
        sum       = {pose_reg[c_reg][31], pose_reg[c_reg]} + {inc_reg[c_reg][31], inc_reg[c_reg]};
        if (sum[32] != sum[31])
            sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            sum_sat = sum[31:0];
    end

    // Select the keyframe to read
    always_comb
    begin
        unique case (state_reg)
            S_INC_A: rd_frame = seg_reg;
            S_INC_B: rd_frame = seg_inc[3:0];
            default: rd_frame = 4'd0;
        endcase
        raddr  = KAW'((int'(cur_reg) * MAX_KEYFRAMES + int'(rd_frame)) * NUM_CHANNELS
                 + int'(c_reg));
        waddr  = KAW'((int'(cur_reg) * MAX_KEYFRAMES + int'(fcnt_cur)) * NUM_CHANNELS
                 + int'(c_reg));
        mem_we = state_reg == S_SAVE;
    end

    // Keyframe memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            kf_mem[waddr] <= pose_reg[c_reg];
        rdata_reg <= kf_mem[raddr];
    end

    // Start a divide once both keyframes are in
    always_comb
    begin
        div_req.start = state_reg == S_INC_C;
        div_req.neg   = diff[32];
        div_req.mag   = diff[32] ? 33'(-diff) : 33'(diff);
    end

    kip_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .divisor (eff_steps),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Hold the step count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            steps_reg <= kip_pkg::STEPS_RESET;
        else if (cfg_we)
            steps_reg <= cfg_wdata;
    end

    // Sequence each transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            c_reg         <= '0;
            cur_reg       <= '0;
            play_reg      <= 1'b0;
            seg_reg       <= 4'd0;
            step_reg      <= 12'd0;
            status_reg    <= kip_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pose_reg[i] <= '0;
                inc_reg[i]  <= '0;
            end
            for (int i = 0; i < NUM_ANIMS; i++)
                fcnt_reg[i] <= 4'd0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg    <= cmd;
                        c_reg      <= '0;
                        status_reg <= kip_pkg::ST_OK;
                        state_reg  <= S_EMIT;
                        case (cmd.opcode)
                            kip_pkg::OP_SET:
                            begin
                                if (int'(cmd.channel_index) < NUM_CHANNELS)
                                    pose_reg[CIW'(cmd.channel_index)] <= cmd.channel_value;
                            end
                            kip_pkg::OP_SAVE:
                            begin
                                if (int'(fcnt_cur) >= MAX_KEYFRAMES)
                                    status_reg <= kip_pkg::ST_FULL;
                                else
                                    state_reg <= S_SAVE;
                            end
                            kip_pkg::OP_SELECT:
                            begin
                                if (int'(cmd.anim_index) < NUM_ANIMS)
                                begin
                                    play_reg <= 1'b0;
                                    cur_reg  <= AIW'(cmd.anim_index);
                                end
                            end
                            kip_pkg::OP_PLAY:
                            begin
                                if (!play_reg && fcnt_cur > 4'd1)
                                begin
                                    seg_reg    <= 4'd0;
                                    step_reg   <= 12'd0;
                                    status_reg <= kip_pkg::ST_STARTED;
                                    state_reg  <= S_LOAD_A;
                                end
                                else
                                begin
                                    play_reg   <= 1'b0;
                                    status_reg <= kip_pkg::ST_STOPPED;
                                end
                            end
                            kip_pkg::OP_TICK:
                            begin
                                if (!play_reg)
                                    status_reg <= kip_pkg::ST_STOPPED;
                                else if (step_reg >= eff_steps)
                                begin
                                    if ({1'b0, seg_inc[3:0]} + 5'd2 > {1'b0, fcnt_cur})
                                    begin
                                        seg_reg    <= 4'd0;
                                        play_reg   <= 1'b0;
                                        status_reg <= kip_pkg::ST_FINISHED;
                                    end
                                    else
                                    begin
                                        seg_reg   <= seg_inc[3:0];
                                        step_reg  <= 12'd0;
                                        state_reg <= S_INC_A;
                                    end
                                end
                                else
                                    state_reg <= S_STEP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SAVE:
                begin
                    // copy pose into the next keyframe, one channel a cycle
                    c_reg <= c_reg + CIW'(1);
                    if (last_c)
                    begin
                        fcnt_reg[cur_reg] <= fcnt_cur + 4'd1;
                        c_reg     <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_LOAD_A:
                    state_reg <= S_LOAD_B;
                S_LOAD_B:
                begin
                    pose_reg[c_reg] <= rdata_reg;
                    c_reg <= last_c ? '0 : c_reg + CIW'(1);
                    state_reg <= last_c ? S_INC_A : S_LOAD_A;
                end
                S_INC_A:
                    state_reg <= S_INC_B;
                S_INC_B:
                begin
                    cur_val_reg <= rdata_reg;
                    state_reg   <= S_INC_C;
                end
                S_INC_C:
                    state_reg <= S_INC_D;
                S_INC_D:
                begin
                    if (div_done)
                    begin
                        inc_reg[c_reg] <= div_quot;
                        if (last_c)
                        begin
                            c_reg     <= '0;
                            play_reg  <= 1'b1;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            c_reg     <= c_reg + CIW'(1);
                            state_reg <= S_INC_A;
                        end
                    end
                end
                S_STEP:
                begin
                    // advance the pose by one increment per channel
                    pose_reg[c_reg] <= sum_sat;
                    if (last_c)
                    begin
                        c_reg     <= '0;
                        step_reg  <= step_reg + 12'd1;
                        state_reg <= S_EMIT;
                    end
                    else
                        c_reg <= c_reg + CIW'(1);
                end
                S_EMIT:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg       <= 1'b1;
                        rsp_reg.status      <= status_reg;
                        rsp_reg.playing     <= play_reg;
                        rsp_reg.frame_count <= fcnt_cur;
                        if (cmd_reg.opcode == kip_pkg::OP_TICK)
                        begin
                            rsp_reg.out_channel <= 4'(c_reg);
                            rsp_reg.out_value   <= pose_reg[c_reg];
                            rsp_reg.last_item   <= last_c;
                            c_reg <= c_reg + CIW'(1);
                            if (last_c)
                                state_reg <= S_IDLE;
                        end
                        else
                        begin
                            rsp_reg.out_channel <= 4'd0;
                            rsp_reg.out_value   <= '0;
                            rsp_reg.last_item   <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign cmd_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`include "keyframe_interpolation_player_top_assert.svh"

    `KIP_ASSERT_NOW(a_play_needs_frames, play_reg, fcnt_cur >= 4'd2)
    `KIP_ASSERT_NEXT(a_div_start_waits, div_req.start, state_reg == S_INC_D)
    `KIP_ASSERT_NEXT(a_emit_holds, state_reg == S_EMIT && rsp_valid_reg && rsp_stall,
                     state_reg == S_EMIT)

endmodule

// ----- rtl/core/kip_div.sv -----
// Serial restoring divider: 33-bit signed difference by 12-bit step count, saturated.
module kip_div (
    input  logic               clk,
    input  logic               rst_n,
    input  kip_pkg::div_req_t  req,
    input  logic [11:0]        divisor,
    output logic               done,
    output logic signed [31:0] quot
);

    logic [11:0] rem_reg;
    logic [32:0] dvd_reg;
    logic [32:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [12:0] trial;
    logic        fits;

    // Form the trial remainder for this step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[32]};
        fits  = trial >= {1'b0, divisor};
    end

    // Iterate one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd33;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Shift the datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.mag;
            neg_reg <= req.neg;
            rem_reg <= 12'd0;
            quo_reg <= 33'd0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[31:0], 1'b0};
            if (fits)
            begin
                rem_reg <= 12'(trial - {1'b0, divisor});
                quo_reg <= {quo_reg[31:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[11:0];
                quo_reg <= {quo_reg[31:0], 1'b0};
            end
        end
    end

    // Apply sign and saturate to 32 bits
    always_comb
    begin
        if (!neg_reg)
            quot = (quo_reg > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(quo_reg[31:0]);
        else
            quot = (quo_reg > 33'h0_8000_0000) ? 32'sh8000_0000 : signed'(-quo_reg[31:0]);
    end

    assign done = done_reg;

endmodule
